### hw/rtl/mhpq_pkg.sv
// Shared types, sizes and codes for the min-heap priority queue.
// No dependencies; imported by the sift-pick logic and the top level.
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 6;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child indices reach 2*CAPACITY, one bit past a count
  localparam int IDX_W    = ADDR_W + 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
  } command_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] min_value;
    logic [OCC_W-1:0]        occupancy;
  } result_t;

  // down-sift decision for one level
  typedef struct packed {
    logic                    move;
    logic [ADDR_W-1:0]       child;
    logic signed [KEY_W-1:0] child_key;
  } pick_t;

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
    return (p - ADDR_W'(1)) >> 1;
  endfunction

  function automatic logic [IDX_W-1:0] left_of(input logic [ADDR_W-1:0] p);
    return IDX_W'({p, 1'b1});
  endfunction

endpackage

### hw/rtl/mhpq_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/mhpq_pick.sv
// Down-sift step: picks the smaller child and decides whether the key moves.
// Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_pick (
  input  logic [mhpq_pkg::ADDR_W-1:0]       pos,
  input  logic [mhpq_pkg::CNT_W-1:0]        fill,
  input  logic signed [mhpq_pkg::KEY_W-1:0] left_key,
  input  logic signed [mhpq_pkg::KEY_W-1:0] right_key,
  input  logic signed [mhpq_pkg::KEY_W-1:0] key,
  output mhpq_pkg::pick_t                   pick
);
  import mhpq_pkg::*;

  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] right_idx;
  logic             has_left;
  logic             has_right;
  logic             take_right;

  assign left_idx  = left_of(pos);
  assign right_idx = left_idx + IDX_W'(1);
  assign has_left  = left_idx < IDX_W'(fill);
  assign has_right = right_idx < IDX_W'(fill);
  // ties go left
  assign take_right = has_right && (right_key < left_key);

  always_comb begin
    pick.child     = take_right ? ADDR_W'(right_idx) : ADDR_W'(left_idx);
    pick.child_key = take_right ? right_key : left_key;
    pick.move      = has_left && (pick.child_key < key);
  end

endmodule

### hw/rtl/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: command FSM, fill count, result.
// Depends on mhpq_pkg, mhpq_ram and mhpq_pick.
//
//   port group      dir  handshake                 payload
//   start/command   in   start && !busy            command_t {cmd, key}
//   done/result     out  done, one cycle, no stall result_t {status, min_value, occupancy}
//
// Keys live in one RAM with two registered read ports; the moving key is held in
// a register and written once at its final slot, where the sift stops.
// Insert: S_UP_CMP moves larger parents down, then S_UP_FIN writes at the root.
// Delete: S_DEL_LD takes root and last key, S_DN_CMP lifts smaller children.
// Refused commands and an insert into an empty heap are answered from S_IDLE.
// Reset clears the count, done and FSM only; unwritten RAM words may be read but are never used.
`timescale 1ns / 1ps

module min_heap_priority_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mhpq_pkg::command_t command,
  output logic               busy,
  output logic               done,
  output mhpq_pkg::result_t  result
);
  import mhpq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UP_CMP = 5'b00010,
    S_UP_FIN = 5'b00100,
    S_DEL_LD = 5'b01000,
    S_DN_CMP = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]        count, count_next;
  logic [ADDR_W-1:0]       pos, pos_next;
  logic [ADDR_W-1:0]       par, par_next;
  logic signed [KEY_W-1:0] key_reg, key_next;
  logic signed [KEY_W-1:0] min_reg, min_next;
  logic [1:0]              status_reg, status_next;
  logic                    done_next;

  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic signed [KEY_W-1:0] wdata;
  logic [ADDR_W-1:0]       raddr_a;
  logic [ADDR_W-1:0]       raddr_b;
  logic signed [KEY_W-1:0] rdata_a;
  logic signed [KEY_W-1:0] rdata_b;
  pick_t                   pick;

  mhpq_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  mhpq_pick u_pick (
    .pos      (pos),
    .fill     (count),
    .left_key (rdata_a),
    .right_key(rdata_b),
    .key      (key_reg),
    .pick     (pick)
  );

  assign busy             = (state != S_IDLE);
  assign result.status    = status_reg;
  assign result.min_value = min_reg;
  assign result.occupancy = OCC_W'(count);

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    par_next    = par;
    key_next    = key_reg;
    min_next    = min_reg;
    status_next = status_reg;
    done_next   = 1'b0;
    we          = 1'b0;
    waddr       = pos;
    wdata       = key_reg;
    raddr_a     = parent_of(par);
    raddr_b     = pos;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (command.cmd == CMD_INSERT) begin
            min_next = '0;
            if (count == CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
            end else begin
              status_next = ST_OK;
              count_next  = count + CNT_W'(1);
              key_next    = command.key;
              if (count == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = command.key;
                done_next = 1'b1;
              end else begin
                pos_next   = ADDR_W'(count);
                par_next   = parent_of(ADDR_W'(count));
                raddr_a    = parent_of(ADDR_W'(count));
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              min_next    = '0;
              done_next   = 1'b1;
            end else begin
              status_next = ST_OK;
              count_next  = count - CNT_W'(1);
              raddr_a     = '0;
              raddr_b     = ADDR_W'(count - CNT_W'(1));
              state_next  = S_DEL_LD;
            end
          end
        end
      end

      S_UP_CMP: begin
        // rdata_a holds the parent; the grandparent read goes out speculatively
        we = 1'b1;
        if (key_reg < rdata_a) begin
          wdata    = rdata_a;
          pos_next = par;
          if (par == '0) begin
            state_next = S_UP_FIN;
          end else begin
            par_next = parent_of(par);
          end
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_UP_FIN: begin
        we         = 1'b1;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_DEL_LD: begin
        min_next   = rdata_a;
        key_next   = rdata_b;
        pos_next   = '0;
        raddr_a    = ADDR_W'(left_of('0));
        raddr_b    = ADDR_W'(left_of('0) + IDX_W'(1));
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (pick.move) begin
          wdata    = pick.child_key;
          pos_next = pick.child;
          raddr_a  = ADDR_W'(left_of(pick.child));
          raddr_b  = ADDR_W'(left_of(pick.child) + IDX_W'(1));
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    pos        <= pos_next;
    par        <= par_next;
    key_reg    <= key_next;
    min_reg    <= min_next;
    status_reg <= status_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is still in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (done && status_reg == ST_FULL) |-> (count == CNT_W'(CAPACITY)))
    else $error("full reported on a heap that is not full");

  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    (done && status_reg == ST_EMPTY) |-> (count == '0 && min_reg == '0))
    else $error("empty reported on a non-empty heap");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !start) |-> !we)
    else $error("key store written while idle");

endmodule
